// ----- hw/rtl/exifdt_pkg.sv -----
// shared constants, types and helpers of the exif capture date extractor
package exifdt_pkg;

	localparam int CAPTURE_BYTES = 65536;
	localparam int ADDR_W = $clog2(CAPTURE_BYTES);
	localparam int CNT_W = $clog2(CAPTURE_BYTES + 1);
	localparam int OFF_W = 35;

	localparam logic [15:0] TAG_EXIF_PTR = 16'h8769;
	localparam logic [15:0] TAG_DT_ORIG = 16'h9003;
	localparam logic [15:0] TAG_DT_DIGI = 16'h9004;
	localparam logic [15:0] TAG_DT = 16'h0132;
	localparam logic [15:0] TIFF_MAGIC = 16'h002A;
	localparam logic [15:0] BOM_II = 16'h4949;
	localparam logic [15:0] BOM_MM = 16'h4D4D;

	localparam logic [7:0] MK_FILL = 8'hFF;
	localparam logic [7:0] MK_SOI = 8'hD8;
	localparam logic [7:0] MK_EOI = 8'hD9;
	localparam logic [7:0] MK_SOS = 8'hDA;
	localparam logic [7:0] MK_APP1 = 8'hE1;
	localparam logic [7:0] MK_TEM = 8'h01;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [31:0] TYPE_ASCII = 32'd2;
	localparam logic [31:0] DATE_CNT_MIN = 32'd19;
	localparam logic [31:0] DATE_CNT_MAX = 32'd64;
	localparam logic [4:0] DATE_LEN = 5'd19;
	localparam logic [13:0] YEAR_MIN = 14'd1900;
	localparam logic [13:0] YEAR_MAX = 14'd2200;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_file;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} out_item_t;

	typedef enum logic [3:0] {
		RS_ZERO, RS_TWO, RS_FOUR, RS_DIR, RS_P, RS_P2, RS_P4, RS_P8, RS_S
	} rd_sel_t;

	typedef enum logic [1:0] {DS_VAL, DS_IFD0, DS_EXIF} dir_src_t;

	typedef struct packed {
		logic ld_pair;
		logic ld_code;
		logic ld_len;
		logic dec_left;
		logic cap_start;
		logic cap_byte;
		logic rd_start;
		rd_sel_t rd_sel;
		logic [4:0] rd_len;
		logic rd_raw_be;
		logic rd_date;
		logic set_order;
		logic ld_ifd0;
		logic ld_exif;
		logic ld_dir;
		dir_src_t dir_src;
		logic ld_cnt;
		logic ent_next;
		logic ld_count;
		logic ld_s;
		logic [15:0] want;
		logic emit;
		logic emit_found;
	} dp_cmd_t;

	typedef struct packed {
		logic b_ff;
		logic b_d8;
		logic b_alone;
		logic b_end;
		logic pair_ff;
		logic len_lt2;
		logic len_cap;
		logic len_two;
		logic left_one;
		logic hdr_pass;
		logic tsize_lt8;
		logic rd_done;
		logic bom_ok;
		logic bom_mm;
		logic magic_ok;
		logic dir_oob;
		logic n_zero;
		logic p_oob;
		logic tag_hit;
		logic val_zero;
		logic type_ascii;
		logic cnt_ok;
		logic s_oob;
		logic date_ok;
	} dp_stat_t;

	// "Exif" then two zero bytes
	function automatic logic [7:0] exif_hdr_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h45;
			3'd1: r = 8'h78;
			3'd2: r = 8'h69;
			3'd3: r = 8'h66;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/exifdt_ram.sv -----
// generic single write port ram with registered read
module exifdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hw/rtl/exifdt_dp.sv -----
// datapath: marker fields, capture store, tiff reader, date parser, result register
module exifdt_dp import exifdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input dp_cmd_t cmd,
	output dp_stat_t stat,
	input logic take,
	output logic out_valid,
	output out_item_t out_item
);
	logic [7:0] pair_q, code_q;
	logic [15:0] left_q, len16;
	logic [CNT_W-1:0] cnt_q, tsize;
	logic hdr_q, order_q;
	logic [31:0] ifd0_q, exif_q, dir_q, s_q;
	logic [OFF_W-1:0] p_q;
	logic [15:0] n_q;
	logic [6:0] count_q;

	logic [ADDR_W-1:0] rd_addr_q;
	logic [4:0] rd_issue_q, rd_recv_q, rd_idx_q;
	logic rd_pend_q, rd_be_q, rd_date_q, rd_done_q;
	logic [31:0] rd_acc_q;
	logic [7:0] rdata;
	logic [OFF_W-1:0] rd_off, rd_end;
	logic rd_oob;

	logic ok_q;
	logic [13:0] yr_q;
	logic [6:0] mo_q, dy_q, hr_q, mi_q, se_q;
	logic is_digit, sep_ok;
	logic [6:0] dig;
	logic cap_we;

	out_item_t out_q;
	logic out_v_q;

	assign len16 = {pair_q, data_byte};
	assign tsize = cnt_q - CNT_W'(6);
	assign cap_we = cmd.cap_byte && (cnt_q < CNT_W'(CAPTURE_BYTES));

	exifdt_ram #(.WIDTH(8), .DEPTH(CAPTURE_BYTES)) u_store (
		.clk(clk),
		.we(cap_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(data_byte),
		.re(rd_issue_q != 5'd0),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	always_comb begin
		case (cmd.rd_sel)
			RS_ZERO: rd_off = '0;
			RS_TWO: rd_off = OFF_W'(2);
			RS_FOUR: rd_off = OFF_W'(4);
			RS_DIR: rd_off = OFF_W'(dir_q);
			RS_P: rd_off = p_q;
			RS_P2: rd_off = p_q + OFF_W'(2);
			RS_P4: rd_off = p_q + OFF_W'(4);
			RS_P8: rd_off = p_q + OFF_W'(8);
			RS_S: rd_off = OFF_W'(s_q);
			default: rd_off = '0;
		endcase
	end
	assign rd_end = rd_off + OFF_W'(cmd.rd_len);
	assign rd_oob = rd_end > OFF_W'(tsize);

	// date character checks
	assign is_digit = (rdata >= CH_ZERO) && (rdata <= CH_NINE);
	assign dig = 7'(rdata - CH_ZERO);
	always_comb begin
		case (rd_idx_q)
			5'd4, 5'd7, 5'd13, 5'd16: sep_ok = (rdata == CH_COLON);
			5'd10: sep_ok = (rdata == CH_SPACE);
			default: sep_ok = is_digit;
		endcase
	end

	// status
	always_comb begin
		stat.b_ff = data_byte == MK_FILL;
		stat.b_d8 = data_byte == MK_SOI;
		stat.b_alone = (data_byte == MK_FILL) || (data_byte == MK_SOI) || (data_byte == MK_TEM)
			|| ((data_byte >= MK_RST0) && (data_byte <= MK_RST7));
		stat.b_end = (data_byte == MK_EOI) || (data_byte == MK_SOS);
		stat.pair_ff = pair_q == MK_FILL;
		stat.len_lt2 = len16 < 16'd2;
		stat.len_cap = (code_q == MK_APP1) && (len16 >= 16'd8);
		stat.len_two = len16 == 16'd2;
		stat.left_one = left_q == 16'd1;
		stat.hdr_pass = hdr_q && ((cnt_q >= CNT_W'(6))
			|| (data_byte == exif_hdr_byte(cnt_q[2:0])));
		stat.tsize_lt8 = tsize < CNT_W'(8);
		stat.rd_done = rd_done_q;
		stat.bom_ok = (rd_acc_q[15:0] == BOM_II) || (rd_acc_q[15:0] == BOM_MM);
		stat.bom_mm = rd_acc_q[15:0] == BOM_MM;
		stat.magic_ok = rd_acc_q[15:0] == TIFF_MAGIC;
		stat.dir_oob = (OFF_W'(dir_q) + OFF_W'(2)) > OFF_W'(tsize);
		stat.n_zero = n_q == 16'd0;
		stat.p_oob = (p_q + OFF_W'(12)) > OFF_W'(tsize);
		stat.tag_hit = rd_acc_q[15:0] == cmd.want;
		stat.val_zero = rd_acc_q == 32'd0;
		stat.type_ascii = rd_acc_q == TYPE_ASCII;
		stat.cnt_ok = (rd_acc_q >= DATE_CNT_MIN) && (rd_acc_q <= DATE_CNT_MAX);
		stat.s_oob = (OFF_W'(rd_acc_q) + OFF_W'(count_q)) > OFF_W'(tsize);
		stat.date_ok = ok_q && (yr_q >= YEAR_MIN) && (yr_q <= YEAR_MAX)
			&& (mo_q >= 7'd1) && (mo_q <= 7'd12) && (dy_q >= 7'd1) && (dy_q <= 7'd31)
			&& (hr_q <= 7'd23) && (mi_q <= 7'd59) && (se_q <= 7'd59);
	end

	// marker walk and capture
	always_ff @(posedge clk) begin
		if (cmd.ld_pair) begin
			pair_q <= data_byte;
		end
		if (cmd.ld_code) begin
			code_q <= data_byte;
		end
		if (cmd.ld_len) begin
			left_q <= len16 - 16'd2;
		end else if (cmd.dec_left) begin
			left_q <= left_q - 16'd1;
		end
		if (cmd.cap_start) begin
			cnt_q <= '0;
			hdr_q <= 1'b1;
		end else if (cap_we) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q < CNT_W'(6)) begin
				hdr_q <= hdr_q && (data_byte == exif_hdr_byte(cnt_q[2:0]));
			end
		end
	end

	// directory walk registers
	always_ff @(posedge clk) begin
		if (cmd.set_order) begin
			order_q <= stat.bom_mm;
		end
		if (cmd.ld_ifd0) begin
			ifd0_q <= rd_acc_q;
		end
		if (cmd.ld_exif) begin
			exif_q <= rd_acc_q;
		end
		if (cmd.ld_dir) begin
			case (cmd.dir_src)
				DS_VAL: dir_q <= rd_acc_q;
				DS_IFD0: dir_q <= ifd0_q;
				DS_EXIF: dir_q <= exif_q;
				default: dir_q <= ifd0_q;
			endcase
		end
		if (cmd.ld_cnt) begin
			n_q <= rd_acc_q[15:0];
			p_q <= OFF_W'(dir_q) + OFF_W'(2);
		end else if (cmd.ent_next) begin
			n_q <= n_q - 16'd1;
			p_q <= p_q + OFF_W'(12);
		end
		if (cmd.ld_count) begin
			count_q <= rd_acc_q[6:0];
		end
		if (cmd.ld_s) begin
			s_q <= rd_acc_q;
		end
	end

	// byte reader: one store read per cycle, assembled by byte order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_issue_q <= '0;
			rd_recv_q <= '0;
			rd_pend_q <= 1'b0;
			rd_done_q <= 1'b0;
		end else begin
			rd_done_q <= 1'b0;
			rd_pend_q <= 1'b0;
			if (cmd.rd_start) begin
				rd_acc_q <= '0;
				rd_idx_q <= '0;
				rd_date_q <= cmd.rd_date;
				rd_be_q <= cmd.rd_raw_be ? 1'b1 : (cmd.set_order ? stat.bom_mm : order_q);
				ok_q <= 1'b1;
				yr_q <= '0;
				mo_q <= '0;
				dy_q <= '0;
				hr_q <= '0;
				mi_q <= '0;
				se_q <= '0;
				if (rd_oob) begin
					rd_issue_q <= '0;
					rd_recv_q <= '0;
					rd_done_q <= 1'b1;
				end else begin
					rd_addr_q <= rd_off[ADDR_W-1:0] + ADDR_W'(6);
					rd_issue_q <= cmd.rd_len;
					rd_recv_q <= cmd.rd_len;
				end
			end else begin
				if (rd_issue_q != 5'd0) begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
					rd_issue_q <= rd_issue_q - 5'd1;
					rd_pend_q <= 1'b1;
				end
				if (rd_pend_q) begin
					rd_idx_q <= rd_idx_q + 5'd1;
					rd_recv_q <= rd_recv_q - 5'd1;
					if (rd_recv_q == 5'd1) begin
						rd_done_q <= 1'b1;
					end
					if (rd_be_q) begin
						rd_acc_q <= {rd_acc_q[23:0], rdata};
					end else begin
						case (rd_idx_q[1:0])
							2'd0: rd_acc_q[7:0] <= rdata;
							2'd1: rd_acc_q[15:8] <= rdata;
							2'd2: rd_acc_q[23:16] <= rdata;
							default: rd_acc_q[31:24] <= rdata;
						endcase
					end
					if (rd_date_q) begin
						ok_q <= ok_q && sep_ok;
						case (rd_idx_q)
							5'd0, 5'd1, 5'd2, 5'd3: yr_q <= 14'(yr_q * 14'd10) + 14'(dig);
							5'd5, 5'd6: mo_q <= 7'(mo_q * 7'd10) + dig;
							5'd8, 5'd9: dy_q <= 7'(dy_q * 7'd10) + dig;
							5'd11, 5'd12: hr_q <= 7'(hr_q * 7'd10) + dig;
							5'd14, 5'd15: mi_q <= 7'(mi_q * 7'd10) + dig;
							5'd17, 5'd18: se_q <= 7'(se_q * 7'd10) + dig;
							default: ;
						endcase
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= '0;
			if (cmd.emit_found) begin
				out_q.found <= 1'b1;
				out_q.year <= yr_q[11:0];
				out_q.month <= mo_q[3:0];
				out_q.day <= dy_q[4:0];
				out_q.hour <= hr_q[4:0];
				out_q.minute <= mi_q[5:0];
				out_q.second <= se_q[5:0];
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_item = out_q;
endmodule

// ----- hw/rtl/exifdt_ctrl.sv -----
// controller: marker walk and tiff directory search sequencer
module exifdt_ctrl import exifdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic eof,
	input logic out_busy,
	input dp_stat_t st,
	output logic src_stall,
	output dp_cmd_t cmd
);
	typedef enum logic [4:0] {
		S_SOI0, S_SOI1, S_MK0, S_MK1, S_LEN0, S_LEN1, S_SKIP, S_CAP, S_DONE,
		W_INIT, W_BOM, W_MAGIC, W_IFD0, F_START, F_CNT, F_ENT, F_TAG, W_EXIF,
		D_TYPE, D_CNT, D_PTR, D_SISSUE, D_STR, W_FIN
	} state_t;

	typedef enum logic [1:0] {LK_EXIFPTR, LK_ORIG, LK_DIGI, LK_DT} lookup_t;

	state_t state_q, nxt;
	lookup_t lk_q, nlk;
	logic eof_q, neof, found_q, nfound;
	logic scan, accept, fail, go_walk, adv;

	assign scan = state_q inside {[S_SOI0:S_DONE]};
	assign src_stall = !scan || out_busy;
	assign accept = src_valid && !src_stall;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		nlk = lk_q;
		neof = eof_q;
		nfound = found_q;
		fail = 1'b0;
		go_walk = 1'b0;
		adv = 1'b0;
		case (lk_q)
			LK_EXIFPTR: cmd.want = TAG_EXIF_PTR;
			LK_ORIG: cmd.want = TAG_DT_ORIG;
			LK_DIGI: cmd.want = TAG_DT_DIGI;
			default: cmd.want = TAG_DT;
		endcase
		case (state_q)
			S_SOI0: if (accept) begin
				if (st.b_ff) nxt = S_SOI1;
				else fail = 1'b1;
			end
			S_SOI1: if (accept) begin
				if (st.b_d8) nxt = S_MK0;
				else fail = 1'b1;
			end
			S_MK0: if (accept) begin
				cmd.ld_pair = 1'b1;
				nxt = S_MK1;
			end
			S_MK1: if (accept) begin
				cmd.ld_code = 1'b1;
				if (!st.pair_ff || st.b_end) fail = 1'b1;
				else if (st.b_alone) nxt = S_MK0;
				else nxt = S_LEN0;
			end
			S_LEN0: if (accept) begin
				cmd.ld_pair = 1'b1;
				nxt = S_LEN1;
			end
			S_LEN1: if (accept) begin
				if (st.len_lt2) begin
					fail = 1'b1;
				end else begin
					cmd.ld_len = 1'b1;
					if (st.len_cap) begin
						cmd.cap_start = 1'b1;
						nxt = S_CAP;
					end else begin
						nxt = st.len_two ? S_MK0 : S_SKIP;
					end
				end
			end
			S_SKIP: if (accept) begin
				cmd.dec_left = 1'b1;
				if (st.left_one) nxt = S_MK0;
			end
			S_CAP: if (accept) begin
				cmd.cap_byte = 1'b1;
				cmd.dec_left = 1'b1;
				if (st.left_one) begin
					if (st.hdr_pass) go_walk = 1'b1;
					else nxt = S_MK0;
				end
			end
			S_DONE: ;
			W_INIT: begin
				if (st.tsize_lt8) begin
					nfound = 1'b0;
					nxt = W_FIN;
				end else begin
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_ZERO;
					cmd.rd_len = 5'd2;
					cmd.rd_raw_be = 1'b1;
					nxt = W_BOM;
				end
			end
			W_BOM: if (st.rd_done) begin
				if (st.bom_ok) begin
					cmd.set_order = 1'b1;
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_TWO;
					cmd.rd_len = 5'd2;
					nxt = W_MAGIC;
				end else begin
					nfound = 1'b0;
					nxt = W_FIN;
				end
			end
			W_MAGIC: if (st.rd_done) begin
				if (st.magic_ok) begin
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_FOUR;
					cmd.rd_len = 5'd4;
					nxt = W_IFD0;
				end else begin
					nfound = 1'b0;
					nxt = W_FIN;
				end
			end
			W_IFD0: if (st.rd_done) begin
				cmd.ld_ifd0 = 1'b1;
				cmd.ld_dir = 1'b1;
				cmd.dir_src = DS_VAL;
				nlk = LK_EXIFPTR;
				nxt = F_START;
			end
			F_START: begin
				if (st.dir_oob) begin
					adv = 1'b1;
				end else begin
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_DIR;
					cmd.rd_len = 5'd2;
					nxt = F_CNT;
				end
			end
			F_CNT: if (st.rd_done) begin
				cmd.ld_cnt = 1'b1;
				nxt = F_ENT;
			end
			F_ENT: begin
				if (st.n_zero || st.p_oob) begin
					adv = 1'b1;
				end else begin
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_P;
					cmd.rd_len = 5'd2;
					nxt = F_TAG;
				end
			end
			F_TAG: if (st.rd_done) begin
				if (st.tag_hit) begin
					cmd.rd_start = 1'b1;
					if (lk_q == LK_EXIFPTR) begin
						cmd.rd_sel = RS_P8;
						cmd.rd_len = 5'd4;
						nxt = W_EXIF;
					end else begin
						cmd.rd_sel = RS_P2;
						cmd.rd_len = 5'd2;
						nxt = D_TYPE;
					end
				end else begin
					cmd.ent_next = 1'b1;
					nxt = F_ENT;
				end
			end
			W_EXIF: if (st.rd_done) begin
				if (st.val_zero) begin
					adv = 1'b1;
				end else begin
					cmd.ld_exif = 1'b1;
					cmd.ld_dir = 1'b1;
					cmd.dir_src = DS_VAL;
					nlk = LK_ORIG;
					nxt = F_START;
				end
			end
			D_TYPE: if (st.rd_done) begin
				if (!st.type_ascii) begin
					adv = 1'b1;
				end else begin
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_P4;
					cmd.rd_len = 5'd4;
					nxt = D_CNT;
				end
			end
			D_CNT: if (st.rd_done) begin
				if (!st.cnt_ok) begin
					adv = 1'b1;
				end else begin
					cmd.ld_count = 1'b1;
					cmd.rd_start = 1'b1;
					cmd.rd_sel = RS_P8;
					cmd.rd_len = 5'd4;
					nxt = D_PTR;
				end
			end
			D_PTR: if (st.rd_done) begin
				if (st.s_oob) begin
					adv = 1'b1;
				end else begin
					cmd.ld_s = 1'b1;
					nxt = D_SISSUE;
				end
			end
			D_SISSUE: begin
				cmd.rd_start = 1'b1;
				cmd.rd_sel = RS_S;
				cmd.rd_len = DATE_LEN;
				cmd.rd_date = 1'b1;
				nxt = D_STR;
			end
			D_STR: if (st.rd_done) begin
				if (st.date_ok) begin
					nfound = 1'b1;
					nxt = W_FIN;
				end else begin
					adv = 1'b1;
				end
			end
			W_FIN: if (!out_busy) begin
				cmd.emit = 1'b1;
				cmd.emit_found = found_q;
				nxt = eof_q ? S_SOI0 : S_DONE;
			end
			default: nxt = S_DONE;
		endcase

		// lookup or date check failed: move on to the next tag to search, or finish as not found after the last one
		if (adv) begin
			case (lk_q)
				LK_EXIFPTR, LK_DIGI: begin
					nlk = LK_DT;
					cmd.ld_dir = 1'b1;
					cmd.dir_src = DS_IFD0;
					nxt = F_START;
				end
				LK_ORIG: begin
					nlk = LK_DIGI;
					nxt = F_START;
				end
				default: begin
					nfound = 1'b0;
					nxt = W_FIN;
				end
			endcase
		end

		if (accept) begin
			if (go_walk) begin
				neof = eof;
				nxt = W_INIT;
			end else begin
				if (state_q != S_DONE && (fail || eof)) begin
					cmd.emit = 1'b1;
					cmd.emit_found = 1'b0;
				end
				if (fail) nxt = S_DONE;
				if (eof) nxt = S_SOI0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SOI0;
			lk_q <= LK_EXIFPTR;
			eof_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= nxt;
			lk_q <= nlk;
			eof_q <= neof;
			found_q <= nfound;
		end
	end
endmodule

// ----- hw/rtl/jpeg_exif_capture_date_extractor.sv -----
// top level of the exif capture date extractor
// usage:
//   src channel carries one file byte per item with an end_of_file mark on
//   the last byte; dst channel carries one result item per file (found flag
//   plus year, month, day, hour, minute, second, all zero when not found)
// flow:
//   bytes are taken one per cycle during the marker walk unless a result
//   waits under dst_stall; a result caused by a byte shows on dst the cycle
//   after that byte is taken; after the last byte of an exif app1 segment
//   the input stalls while the tiff directories are walked through the
//   single read port of the capture store, one byte per read: 2-byte and
//   4-byte field reads, the date string, and one tag read per directory
//   entry visited
// reset:
//   arst_n clears the controller, the byte reader and the result valid flag;
//   the capture store needs no clearing: only current segment bytes are read
// back pressure:
//   while a result waits under dst_stall the input stalls, so no result is
//   lost or overwritten
module jpeg_exif_capture_date_extractor import exifdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	output logic src_stall,
	input in_item_t src_item,
	output logic dst_valid,
	input logic dst_stall,
	output out_item_t dst_item
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic out_busy;

	// result register still held by the receiver
	assign out_busy = dst_valid && dst_stall;

	exifdt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.eof(src_item.end_of_file),
		.out_busy(out_busy),
		.st(stat),
		.src_stall(src_stall),
		.cmd(cmd)
	);

	exifdt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(src_item.data_byte),
		.cmd(cmd),
		.stat(stat),
		.take(dst_valid && !dst_stall),
		.out_valid(dst_valid),
		.out_item(dst_item)
	);
endmodule

// ----- hw/rtl/exifdt_checker.sv -----
// port level checks of the exif capture date extractor and their binding
module exifdt_checker import exifdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic src_stall,
	input in_item_t src_item,
	input logic dst_valid,
	input logic dst_stall,
	input out_item_t dst_item
);
	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
		else $error("result changed while stalled");

	// no input taken while a result waits
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |-> src_stall)
		else $error("input taken while result stalled");

	// not found means all date fields are zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_item.found |-> dst_item.year == 12'd0 && dst_item.month == 4'd0
			&& dst_item.day == 5'd0 && dst_item.hour == 5'd0 && dst_item.minute == 6'd0
			&& dst_item.second == 6'd0)
		else $error("nonzero date without found");

	// a found date is in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.found |-> dst_item.year >= 12'd1900 && dst_item.year <= 12'd2200
			&& dst_item.month >= 4'd1 && dst_item.month <= 4'd12 && dst_item.day >= 5'd1
			&& dst_item.hour <= 5'd23 && dst_item.minute <= 6'd59 && dst_item.second <= 6'd59)
		else $error("found date out of range");
endmodule

bind jpeg_exif_capture_date_extractor exifdt_checker u_chk (.*);
